// ===== src/utf8_to_ucs2_decoder_assert.svh =====
// Assertion macros shared by the decoder's checker
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define U8U2_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define U8U2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds through reset
`define U8U2_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/u8u2_pkg.sv =====
// Constants for the UTF-8 to UCS-2 decoder
package u8u2_pkg;

    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_CODE   = 8'h80;
    localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE  = 8'hE0;
    localparam logic [7:0]  LEAD2_BITS  = 8'h1F;
    localparam logic [7:0]  LEAD3_BITS  = 8'h0F;
    localparam logic [15:0] MARK_CHAR   = 16'd63;

endpackage

// ===== src/utf8_to_ucs2_decoder.sv =====
// UTF-8 to UCS-2 decoder: top level
//
// Input channel: one UTF-8 byte per word on i_data_byte, taken at an edge where
// i_valid is high and o_stall is low. A zero byte ends a string and gives no
// output word of its own.
// Output channel: one 16-bit code unit per word on o_code_unit with o_bad set
// on substituted '?' marks and o_last_of_run on the final word caused by one
// input byte; a word moves when o_valid is high and i_stall is low.
// An accepted byte is decoded from the input register, and its results are
// registered in the output register. A byte that yields no word (lead byte,
// terminator) or one word is retired without holding the input, so a steady
// stream runs at one byte a cycle while the receiver does not stall.
// A byte that breaks a pending sequence yields up to three words, one per cycle
// through the output register while the receiver does not stall, and o_stall
// holds the input meanwhile. When the receiver stalls, the output register
// holds its word and the input register backs up behind it after one more byte.
// Reset clears the valid flags of both registers and returns the sequence state to idle.
module utf8_to_ucs2_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_unit,
    output logic        o_bad,
    output logic        o_last_of_run
);

    // input register
    logic        r_byte_vld, n_byte_vld;
    logic [7:0]  r_byte;
    logic [1:0]  r_idx, n_idx;

    // sequence state
    logic [1:0]  r_needed, n_needed;
    logic [1:0]  r_taken, n_taken;
    logic [15:0] r_partial, n_partial;

    // output register
    logic        r_out_vld, n_out_vld;
    logic [15:0] r_out_code, n_out_code;
    logic        r_out_bad, n_out_bad;
    logic        r_out_last, n_out_last;

    logic        w_pending, w_cont, w_complete;
    logic [15:0] w_step;
    logic [1:0]  w_marks, w_cnt;
    logic        w_fresh_emit, w_fresh_bad;
    logic [15:0] w_fresh_code;
    logic [1:0]  w_lead_needed;
    logic [15:0] w_lead_partial;
    logic        w_out_load, w_emit, w_consume, w_accept;
    logic [15:0] w_res_code;
    logic        w_res_bad;

    assign w_pending  = (r_needed != 2'd0);
    assign w_cont     = ((r_byte & u8u2_pkg::CONT_MASK) == u8u2_pkg::CONT_CODE);
    assign w_step     = {r_partial[9:0], r_byte[5:0]};
    assign w_complete = w_pending && w_cont && (r_needed == 2'd1);

    // fresh handling of a byte that does not continue a pending sequence
    always_comb begin
        w_fresh_emit   = 1'b0;
        w_fresh_bad    = 1'b0;
        w_fresh_code   = {8'd0, r_byte};
        w_lead_needed  = 2'd0;
        w_lead_partial = 16'd0;
        if (r_byte == 8'd0) begin
            w_fresh_emit = 1'b0;
        end else if (!r_byte[7]) begin
            w_fresh_emit = 1'b1;
        end else if ((r_byte & u8u2_pkg::LEAD2_MASK) == u8u2_pkg::LEAD2_CODE) begin
            w_lead_needed  = 2'd1;
            w_lead_partial = {8'd0, r_byte & u8u2_pkg::LEAD2_BITS};
        end else if ((r_byte & u8u2_pkg::LEAD3_MASK) == u8u2_pkg::LEAD3_CODE) begin
            w_lead_needed  = 2'd2;
            w_lead_partial = {8'd0, r_byte & u8u2_pkg::LEAD3_BITS};
        end else begin
            // stray continuation, four-byte lead or invalid byte
            w_fresh_emit = 1'b1;
            w_fresh_bad  = 1'b1;
            w_fresh_code = u8u2_pkg::MARK_CHAR;
        end
    end

    // result count: one word for a completed sequence; else marks for a broken sequence, then the fresh word
    always_comb begin
        w_marks = 2'd0;
        w_cnt   = 2'd0;
        if (w_pending && w_cont) begin
            w_cnt = w_complete ? 2'd1 : 2'd0;
        end else begin
            if (w_pending) begin
                w_marks = (r_taken == 2'd0) ? 2'd1 : 2'd2;
            end
            w_cnt = w_marks + {1'b0, w_fresh_emit};
        end
    end

    always_comb begin
        if (r_idx < w_marks) begin
            w_res_code = u8u2_pkg::MARK_CHAR;
            w_res_bad  = 1'b1;
        end else if (w_complete) begin
            w_res_code = w_step;
            w_res_bad  = 1'b0;
        end else begin
            w_res_code = w_fresh_code;
            w_res_bad  = w_fresh_bad;
        end
    end

    assign w_out_load = !r_out_vld || !i_stall;
    assign w_emit     = r_byte_vld && (w_cnt != 2'd0) && w_out_load;
    assign w_consume  = r_byte_vld &&
                        ((w_cnt == 2'd0) || (w_emit && (r_idx == w_cnt - 2'd1)));
    assign o_stall    = r_byte_vld && !w_consume;
    assign w_accept   = i_valid && !o_stall;

    always_comb begin
        n_byte_vld = r_byte_vld;
        n_idx      = r_idx;
        if (w_accept) begin
            n_byte_vld = 1'b1;
        end else if (w_consume) begin
            n_byte_vld = 1'b0;
        end
        if (w_consume) begin
            n_idx = 2'd0;
        end else if (w_emit) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_comb begin
        n_needed  = r_needed;
        n_taken   = r_taken;
        n_partial = r_partial;
        if (w_consume) begin
            if (w_pending && w_cont) begin
                if (w_complete) begin
                    n_needed  = 2'd0;
                    n_taken   = 2'd0;
                    n_partial = 16'd0;
                end else begin
                    n_needed  = r_needed - 2'd1;
                    n_taken   = r_taken + 2'd1;
                    n_partial = w_step;
                end
            end else begin
                n_needed  = w_lead_needed;
                n_taken   = 2'd0;
                n_partial = w_lead_partial;
            end
        end
    end

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out_code = r_out_code;
        n_out_bad  = r_out_bad;
        n_out_last = r_out_last;
        if (w_emit) begin
            n_out_vld  = 1'b1;
            n_out_code = w_res_code;
            n_out_bad  = w_res_bad;
            n_out_last = (r_idx == w_cnt - 2'd1);
        end else if (!i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_vld <= 1'b0;
            r_idx      <= 2'd0;
            r_needed   <= 2'd0;
            r_taken    <= 2'd0;
            r_partial  <= 16'd0;
            r_out_vld  <= 1'b0;
        end else begin
            r_byte_vld <= n_byte_vld;
            r_idx      <= n_idx;
            r_needed   <= n_needed;
            r_taken    <= n_taken;
            r_partial  <= n_partial;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_data_byte;
        end
        r_out_code <= n_out_code;
        r_out_bad  <= n_out_bad;
        r_out_last <= n_out_last;
    end

    assign o_valid       = r_out_vld;
    assign o_code_unit   = r_out_code;
    assign o_bad         = r_out_bad;
    assign o_last_of_run = r_out_last;

endmodule

// ===== src/u8u2_checker.sv =====
// Port-level checks for the UTF-8 to UCS-2 decoder, bound to the top level
`include "utf8_to_ucs2_decoder_assert.svh"

module u8u2_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_code_unit,
    input logic        o_bad,
    input logic        o_last_of_run
);

    `U8U2_ASSERT_NOW(a_bad_is_mark, o_valid && o_bad, o_code_unit == u8u2_pkg::MARK_CHAR, "bad word is not a mark")
    // only flush marks can precede another word from the same byte
    `U8U2_ASSERT_NOW(a_early_is_bad, o_valid && !o_last_of_run, o_bad, "non-final word is not a mark")
    `U8U2_ASSERT_NEXT(a_run_continues, o_valid && !o_last_of_run && !i_stall, o_valid, "gap inside a run of words")
    `U8U2_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_valid, "output valid after reset")

endmodule

bind utf8_to_ucs2_decoder u8u2_checker u_u8u2_checker (.*);
